// ===== src/cadq_pkg.sv =====
// Package for the class-aware drop queue: payload structs, entry layout,
// status and class codes, controller command and datapath status structs.
// No dependencies.
package cadq_pkg;

   localparam int QUEUE_DEPTH       = 16;
   localparam int MAX_TOPIC_BYTES   = 128;
   localparam int MAX_PAYLOAD_BYTES = 512;
   localparam int TAG_WIDTH         = 16;

   localparam int IDX_W    = $clog2(QUEUE_DEPTH);
   localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W    = IDX_W + 1;
   localparam int REM_W    = 5;
   localparam int RESULT_LIMIT = 16;

   localparam logic       CMD_ENQUEUE   = 1'b0;
   localparam logic       CMD_POP       = 1'b1;
   localparam logic [1:0] CLS_AVAIL     = 2'd0;
   localparam logic [1:0] CLS_DISCOVERY = 2'd1;
   localparam logic [1:0] CLS_TELEMETRY = 2'd2;
   localparam logic [1:0] CLS_UNUSED    = 2'd3;
   localparam logic [1:0] QOS_RELIABLE  = 2'd1;
   localparam logic [1:0] QOS_MAX       = 2'd2;
   localparam logic [1:0] QOS_OVER      = 2'd3;

   typedef enum logic [2:0] {
      STAT_QUEUED  = 3'd0,
      STAT_DROPPED = 3'd1,
      STAT_INVALID = 3'd2,
      STAT_FULL    = 3'd3,
      STAT_SENT    = 3'd4,
      STAT_NONE    = 3'd5
   } status_type;

   typedef struct packed {
      logic        command;
      logic [1:0]  message_class;
      logic        retain_flag;
      logic [15:0] message_tag;
      logic        text_missing;
      logic [7:0]  topic_length;
      logic [9:0]  payload_length;
      logic [4:0]  pop_count;
      logic        sink_connected;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  out_class;
      logic [1:0]  out_qos;
      logic        out_retain;
      logic [15:0] out_tag;
      logic        last;
      logic [4:0]  queue_count;
      logic [31:0] dropped_count;
      logic [31:0] rejected_count;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0]           cls;
      logic [1:0]           qos;
      logic                 retain;
      logic [TAG_WIDTH-1:0] tag;
   } entry_type;

   typedef enum logic [1:0] {
      RD_IDX      = 2'd0,
      RD_IDX_NEXT = 2'd1,
      RD_HEAD     = 2'd2
   } rd_src_type;

   typedef enum logic [1:0] {
      WR_NEW_AT_COUNT = 2'd0,
      WR_NEW_AT_LAST  = 2'd1,
      WR_SHIFT        = 2'd2
   } wr_src_type;

   typedef struct packed {
      logic       item_load;
      logic       rd_en;
      rd_src_type rd_src;
      logic       wr_en;
      wr_src_type wr_src;
      logic       idx_clear;
      logic       idx_inc;
      logic       rem_load;
      logic       rem_dec;
      logic       pop_head;
      logic       count_inc;
      logic       drop_inc;
      logic       reject_inc;
      logic       emit;
      status_type status;
   } ctrl_cmd_type;

   typedef struct packed {
      logic cmd_pop;
      logic item_invalid;
      logic is_full;
      logic pop_none;
      logic rd_telemetry;
      logic idx_last;
      logic rem_last;
      logic out_free;
   } dp_stat_type;

   function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] head,
                                                input logic [IDX_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = {1'b0, head} + {1'b0, off};
      if (sum >= SUM_W'(QUEUE_DEPTH)) begin
         sum = sum - SUM_W'(QUEUE_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

// ===== src/cadq_ctrl.sv =====
// Controller state machine of the class-aware drop queue.
// Drives cadq_dpath through cadq_pkg::ctrl_cmd_type; reads cadq_pkg::dp_stat_type.
module cadq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  cadq_pkg::dp_stat_type  stat,
   output cadq_pkg::ctrl_cmd_type cmd
);

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_DECIDE   = 9'b000000010,
      S_SCAN_RD  = 9'b000000100,
      S_SCAN_CHK = 9'b000001000,
      S_SHIFT_RD = 9'b000010000,
      S_SHIFT_WR = 9'b000100000,
      S_PLACE    = 9'b001000000,
      S_POP_RD   = 9'b010000000,
      S_POP_EMIT = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_src = cadq_pkg::RD_IDX;
      cmd.wr_src = cadq_pkg::WR_NEW_AT_COUNT;
      cmd.status = cadq_pkg::STAT_QUEUED;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.item_load = 1'b1;
               state_in      = S_DECIDE;
            end
         end
         S_DECIDE: begin
            priority if (stat.cmd_pop) begin
               if (stat.pop_none) begin
                  if (stat.out_free) begin
                     cmd.emit   = 1'b1;
                     cmd.status = cadq_pkg::STAT_NONE;
                     state_in   = S_IDLE;
                  end
               end else begin
                  cmd.rem_load = 1'b1;
                  state_in     = S_POP_RD;
               end
            end else if (stat.item_invalid) begin
               if (stat.out_free) begin
                  cmd.emit       = 1'b1;
                  cmd.reject_inc = 1'b1;
                  cmd.status     = cadq_pkg::STAT_INVALID;
                  state_in       = S_IDLE;
               end
            end else if (!stat.is_full) begin
               if (stat.out_free) begin
                  cmd.wr_en     = 1'b1;
                  cmd.wr_src    = cadq_pkg::WR_NEW_AT_COUNT;
                  cmd.count_inc = 1'b1;
                  cmd.emit      = 1'b1;
                  cmd.status    = cadq_pkg::STAT_QUEUED;
                  state_in      = S_IDLE;
               end
            end else begin
               cmd.idx_clear = 1'b1;
               state_in      = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_src = cadq_pkg::RD_IDX;
            state_in   = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            priority if (stat.rd_telemetry) begin
               state_in = S_SHIFT_RD;
            end else if (stat.idx_last) begin
               if (stat.out_free) begin
                  cmd.emit       = 1'b1;
                  cmd.reject_inc = 1'b1;
                  cmd.status     = cadq_pkg::STAT_FULL;
                  state_in       = S_IDLE;
               end
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SCAN_RD;
            end
         end
         S_SHIFT_RD: begin
            if (stat.idx_last) begin
               state_in = S_PLACE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_src = cadq_pkg::RD_IDX_NEXT;
               state_in   = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_src  = cadq_pkg::WR_SHIFT;
            cmd.idx_inc = 1'b1;
            state_in    = S_SHIFT_RD;
         end
         S_PLACE: begin
            if (stat.out_free) begin
               cmd.wr_en    = 1'b1;
               cmd.wr_src   = cadq_pkg::WR_NEW_AT_LAST;
               cmd.drop_inc = 1'b1;
               cmd.emit     = 1'b1;
               cmd.status   = cadq_pkg::STAT_DROPPED;
               state_in     = S_IDLE;
            end
         end
         S_POP_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_src = cadq_pkg::RD_HEAD;
            state_in   = S_POP_EMIT;
         end
         S_POP_EMIT: begin
            if (stat.out_free) begin
               cmd.emit     = 1'b1;
               cmd.status   = cadq_pkg::STAT_SENT;
               cmd.pop_head = 1'b1;
               cmd.rem_dec  = 1'b1;
               state_in     = stat.rem_last ? S_IDLE : S_POP_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/cadq_dpath.sv =====
// Datapath of the class-aware drop queue: entry memory, ring pointers,
// counters, telemetry QoS register and result register. Uses cadq_pkg.
module cadq_dpath (
   input  logic                      clock,
   input  logic                      reset,
   input  cadq_pkg::req_payload_type req_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output cadq_pkg::rsp_payload_type rsp_payload,
   input  cadq_pkg::ctrl_cmd_type    cmd,
   output cadq_pkg::dp_stat_type     stat
);

   cadq_pkg::entry_type       mem_ff [cadq_pkg::QUEUE_DEPTH];
   cadq_pkg::entry_type       rd_data_ff;
   cadq_pkg::req_payload_type item_ff;
   logic [cadq_pkg::IDX_W-1:0] head_ff, head_in;
   logic [cadq_pkg::CNT_W-1:0] count_ff, count_in;
   logic [cadq_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [cadq_pkg::REM_W-1:0] rem_ff, rem_in;
   logic [31:0]               dropped_ff, dropped_in;
   logic [31:0]               rejected_ff, rejected_in;
   logic [1:0]                qos_ff, qos_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   cadq_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic [cadq_pkg::IDX_W-1:0] rd_addr, wr_addr;
   cadq_pkg::entry_type       new_entry, wr_data;
   logic [cadq_pkg::REM_W-1:0] want;
   logic                      out_free;

   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      stat.cmd_pop      = (item_ff.command == cadq_pkg::CMD_POP);
      stat.item_invalid = item_ff.text_missing
                       || (item_ff.message_class == cadq_pkg::CLS_UNUSED)
                       || (item_ff.topic_length == '0)
                       || (item_ff.topic_length >= 8'(cadq_pkg::MAX_TOPIC_BYTES))
                       || (item_ff.payload_length >= 10'(cadq_pkg::MAX_PAYLOAD_BYTES));
      stat.is_full      = (count_ff >= cadq_pkg::CNT_W'(cadq_pkg::QUEUE_DEPTH));
      stat.pop_none     = !item_ff.sink_connected || (item_ff.pop_count == '0)
                       || (count_ff == '0);
      stat.rd_telemetry = (rd_data_ff.cls == cadq_pkg::CLS_TELEMETRY);
      stat.idx_last     = (idx_ff == cadq_pkg::IDX_W'(cadq_pkg::QUEUE_DEPTH - 1));
      stat.rem_last     = (rem_ff == cadq_pkg::REM_W'(1));
      stat.out_free     = out_free;
   end

   always_comb begin
      new_entry.cls    = item_ff.message_class;
      new_entry.retain = item_ff.retain_flag;
      new_entry.qos    = (item_ff.message_class == cadq_pkg::CLS_TELEMETRY)
                         ? qos_ff : cadq_pkg::QOS_RELIABLE;
      new_entry.tag    = cadq_pkg::TAG_WIDTH'(item_ff.message_tag);

      unique case (cmd.rd_src)
         cadq_pkg::RD_IDX:      rd_addr = cadq_pkg::ring_pos(head_ff, idx_ff);
         cadq_pkg::RD_IDX_NEXT: rd_addr = cadq_pkg::ring_pos(head_ff, idx_ff + 1'b1);
         cadq_pkg::RD_HEAD:     rd_addr = head_ff;
         default:               rd_addr = head_ff;
      endcase

      unique case (cmd.wr_src)
         cadq_pkg::WR_NEW_AT_COUNT: begin
            wr_addr = cadq_pkg::ring_pos(head_ff, count_ff[cadq_pkg::IDX_W-1:0]);
            wr_data = new_entry;
         end
         cadq_pkg::WR_NEW_AT_LAST: begin
            wr_addr = cadq_pkg::ring_pos(head_ff,
                         cadq_pkg::IDX_W'(cadq_pkg::QUEUE_DEPTH - 1));
            wr_data = new_entry;
         end
         cadq_pkg::WR_SHIFT: begin
            wr_addr = cadq_pkg::ring_pos(head_ff, idx_ff);
            wr_data = rd_data_ff;
         end
         default: begin
            wr_addr = '0;
            wr_data = new_entry;
         end
      endcase
   end

   always_comb begin
      head_in     = head_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      rem_in      = rem_ff;
      dropped_in  = dropped_ff;
      rejected_in = rejected_ff;
      qos_in      = qos_ff;
      want        = (item_ff.pop_count > cadq_pkg::REM_W'(cadq_pkg::RESULT_LIMIT))
                    ? cadq_pkg::REM_W'(cadq_pkg::RESULT_LIMIT) : item_ff.pop_count;

      if (csr_valid) begin
         qos_in = (csr_data == cadq_pkg::QOS_OVER) ? cadq_pkg::QOS_MAX : csr_data;
      end
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.rem_load) begin
         rem_in = (int'(count_ff) < int'(want)) ? cadq_pkg::REM_W'(count_ff) : want;
      end else if (cmd.rem_dec) begin
         rem_in = rem_ff - 1'b1;
      end
      if (cmd.pop_head) begin
         head_in  = cadq_pkg::ring_pos(head_ff, cadq_pkg::IDX_W'(1));
         count_in = count_ff - 1'b1;
      end else if (cmd.count_inc) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.drop_inc) begin
         dropped_in = dropped_ff + 32'd1;
      end
      if (cmd.reject_inc) begin
         rejected_in = rejected_ff + 32'd1;
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !out_free;
      if (cmd.emit) begin
         rsp_valid_in          = 1'b1;
         rsp_in                = '0;
         rsp_in.status         = cmd.status;
         rsp_in.queue_count    = 5'(count_in);
         rsp_in.dropped_count  = dropped_in;
         rsp_in.rejected_count = rejected_in;
         rsp_in.last           = 1'b1;
         if (cmd.status == cadq_pkg::STAT_SENT) begin
            rsp_in.out_class  = rd_data_ff.cls;
            rsp_in.out_qos    = rd_data_ff.qos;
            rsp_in.out_retain = rd_data_ff.retain;
            rsp_in.out_tag    = 16'(rd_data_ff.tag);
            rsp_in.last       = stat.rem_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.item_load) begin
         item_ff <= req_payload;
      end
      idx_ff <= idx_in;
      rem_ff <= rem_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         dropped_ff   <= '0;
         rejected_ff  <= '0;
         qos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rejected_ff  <= rejected_in;
         qos_ff       <= qos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_head |-> count_ff != '0)
      else $error("pop from empty ring");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_en && cmd.wr_src == cadq_pkg::WR_NEW_AT_COUNT)
      |-> count_ff < cadq_pkg::CNT_W'(cadq_pkg::QUEUE_DEPTH))
      else $error("append into full ring");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.status == cadq_pkg::STAT_DROPPED)
      |-> count_ff == cadq_pkg::CNT_W'(cadq_pkg::QUEUE_DEPTH))
      else $error("eviction while ring not full");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("result register overwritten while stalled");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.count_inc |=> count_ff <= cadq_pkg::CNT_W'(cadq_pkg::QUEUE_DEPTH))
      else $error("entry count above depth");

endmodule

// ===== src/class_aware_drop_queue.sv =====
// Class-aware drop queue: a 16-entry ring of outgoing messages that evicts
// its oldest telemetry entry when full. An item is registered in S_IDLE and
// decided in S_DECIDE. A full ring is scanned from the head for a telemetry
// entry; if none is found the enqueue is refused, else the entries behind it
// are shifted one place toward the head and the new entry is written at the
// last slot. A pop reads and emits one entry at a time. The entry memory has
// a single registered read port.
// The result register holds one beat, so a new item is taken while the
// previous result still waits on rsp_stall.
// Depends on cadq_pkg, cadq_ctrl and cadq_dpath.
module class_aware_drop_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  cadq_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output cadq_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_data
);

   cadq_pkg::ctrl_cmd_type cmd;
   cadq_pkg::dp_stat_type  stat;

   cadq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   cadq_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule

// ===== sim/class_aware_drop_queue_test.sv =====
// Self-checking testbench for class_aware_drop_queue: random and directed beats
// checked against a cycle-free model of the ring. Depends on cadq_pkg and the RTL.
`timescale 1ns / 100ps

module class_aware_drop_queue_test;

   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 300;
   localparam int SETTLE      = 40;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   cadq_pkg::req_payload_type req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   cadq_pkg::rsp_payload_type rsp_payload;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [1:0]                csr_data = '0;

   cadq_pkg::entry_type       shadow_ring [cadq_pkg::QUEUE_DEPTH];
   int                        shadow_head = 0;
   int                        shadow_count = 0;
   logic [31:0]               shadow_dropped = '0;
   logic [31:0]               shadow_rejected = '0;
   logic [1:0]                shadow_qos = '0;

   cadq_pkg::rsp_payload_type predicted_beats [$];
   cadq_pkg::req_payload_type pending_items [$];
   int                        items_queued = 0;
   int                        items_accepted = 0;
   int                        beats_seen = 0;
   int                        mismatches = 0;
   int                        cycle_count = 0;
   int                        holds_requested = 0;
   int                        holds_done = 0;
   int                        hold_left = 0;
   int                        stall_left = 0;
   int                        send_gap = 0;
   bit                        quiet = 1'b0;

   class_aware_drop_queue DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int ring_slot(input int offset);
      return (shadow_head + offset) % cadq_pkg::QUEUE_DEPTH;
   endfunction

   task automatic predict_queue_results(input cadq_pkg::req_payload_type it);
      cadq_pkg::rsp_payload_type r;
      cadq_pkg::entry_type       e;
      int                        n, p, s, i;
      bit                        found;
      r = '0;
      if (it.command == cadq_pkg::CMD_ENQUEUE) begin
         if (it.text_missing || it.message_class == cadq_pkg::CLS_UNUSED ||
             it.topic_length == 0 ||
             it.topic_length >= cadq_pkg::MAX_TOPIC_BYTES ||
             it.payload_length >= cadq_pkg::MAX_PAYLOAD_BYTES) begin
            shadow_rejected++;
            r.status = cadq_pkg::STAT_INVALID;
         end else begin
            r.status = cadq_pkg::STAT_QUEUED;
            found = 1'b1;
            if (shadow_count >= cadq_pkg::QUEUE_DEPTH) begin
               found = 1'b0;
               for (p = 0; p < shadow_count && !found; p++) begin
                  if (shadow_ring[ring_slot(p)].cls == cadq_pkg::CLS_TELEMETRY) begin
                     for (s = p; s + 1 < shadow_count; s++) begin
                        shadow_ring[ring_slot(s)] = shadow_ring[ring_slot(s + 1)];
                     end
                     shadow_count--;
                     shadow_dropped++;
                     found = 1'b1;
                  end
               end
               r.status = found ? cadq_pkg::STAT_DROPPED : cadq_pkg::STAT_FULL;
               if (!found) begin
                  shadow_rejected++;
               end
            end
            if (found) begin
               e.cls    = it.message_class;
               e.qos    = (it.message_class == cadq_pkg::CLS_TELEMETRY)
                          ? shadow_qos : cadq_pkg::QOS_RELIABLE;
               e.retain = it.retain_flag;
               e.tag    = it.message_tag[cadq_pkg::TAG_WIDTH-1:0];
               shadow_ring[ring_slot(shadow_count)] = e;
               shadow_count++;
            end
         end
         r.last           = 1'b1;
         r.queue_count    = 5'(shadow_count);
         r.dropped_count  = shadow_dropped;
         r.rejected_count = shadow_rejected;
         predicted_beats.push_back(r);
      end else begin
         n = it.pop_count;
         if (n > shadow_count) n = shadow_count;
         if (n > cadq_pkg::RESULT_LIMIT) n = cadq_pkg::RESULT_LIMIT;
         if (!it.sink_connected || n == 0) begin
            r.status         = cadq_pkg::STAT_NONE;
            r.last           = 1'b1;
            r.queue_count    = 5'(shadow_count);
            r.dropped_count  = shadow_dropped;
            r.rejected_count = shadow_rejected;
            predicted_beats.push_back(r);
         end else begin
            for (i = 0; i < n; i++) begin
               e = shadow_ring[ring_slot(0)];
               shadow_head = ring_slot(1);
               shadow_count--;
               r.status         = cadq_pkg::STAT_SENT;
               r.out_class      = e.cls;
               r.out_qos        = e.qos;
               r.out_retain     = e.retain;
               r.out_tag        = 16'(e.tag);
               r.last           = (i + 1 == n);
               r.queue_count    = 5'(shadow_count);
               r.dropped_count  = shadow_dropped;
               r.rejected_count = shadow_rejected;
               predicted_beats.push_back(r);
            end
         end
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   task automatic check_beat(input cadq_pkg::rsp_payload_type got);
      cadq_pkg::rsp_payload_type want;
      beats_seen++;
      if (predicted_beats.size() == 0) begin
         mismatches++;
         $display("%0t: beat expected none, got %0h", $time, got);
      end else begin
         want = predicted_beats.pop_front();
         check_field("status", want.status, got.status);
         check_field("out_class", want.out_class, got.out_class);
         check_field("out_qos", want.out_qos, got.out_qos);
         check_field("out_retain", want.out_retain, got.out_retain);
         check_field("out_tag", want.out_tag, got.out_tag);
         check_field("last", want.last, got.last);
         check_field("queue_count", want.queue_count, got.queue_count);
         check_field("dropped_count", want.dropped_count, got.dropped_count);
         check_field("rejected_count", want.rejected_count, got.rejected_count);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            predict_queue_results(req_payload);
            items_accepted++;
         end
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0 && (quiet || $urandom_range(0, 4) != 0)) begin
            req_valid   <= 1'b1;
            req_payload <= pending_items.pop_front();
         end else begin
            req_valid <= 1'b0;
            if (pending_items.size() > 0) send_gap = $urandom_range(0, 2);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_beat(rsp_payload);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (holds_done < holds_requested) begin
            holds_done++;
            hold_left = LONG_HOLD;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d beats outstanding", $time, predicted_beats.size());
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic cadq_pkg::req_payload_type random_bits();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[$bits(cadq_pkg::req_payload_type)-1:0];
   endfunction

   function automatic logic [1:0] random_class();
      if ($urandom_range(0, 1)) return cadq_pkg::CLS_TELEMETRY;
      return $urandom_range(0, 1) ? cadq_pkg::CLS_AVAIL : cadq_pkg::CLS_DISCOVERY;
   endfunction

   function automatic cadq_pkg::req_payload_type make_message(input logic [1:0] cls);
      cadq_pkg::req_payload_type it;
      it                = random_bits();
      it.command        = cadq_pkg::CMD_ENQUEUE;
      it.message_class  = cls;
      it.text_missing   = 1'b0;
      it.topic_length   = 8'($urandom_range(1, cadq_pkg::MAX_TOPIC_BYTES - 1));
      it.payload_length = 10'($urandom_range(0, cadq_pkg::MAX_PAYLOAD_BYTES - 1));
      return it;
   endfunction

   function automatic cadq_pkg::req_payload_type make_pop(input int count,
                                                          input bit connected);
      cadq_pkg::req_payload_type it;
      it                = random_bits();
      it.command        = cadq_pkg::CMD_POP;
      it.pop_count      = 5'(count);
      it.sink_connected = connected;
      return it;
   endfunction

   task automatic send_item(input cadq_pkg::req_payload_type it);
      pending_items.push_back(it);
      items_queued++;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (items_accepted != items_queued || predicted_beats.size() != 0);
   endtask

   task automatic write_qos(input logic [1:0] value);
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      shadow_qos = (value == cadq_pkg::QOS_OVER) ? cadq_pkg::QOS_MAX : value;
      csr_valid <= 1'b0;
   endtask

   task automatic queue_random_items(input int count);
      int target, pick, k;
      target = items_queued + count;
      while (items_queued < target) begin
         pick = $urandom_range(0, 19);
         if (pick <= 1) begin
            // drain, then fill with unevictable classes until the ring refuses
            send_item(make_pop(cadq_pkg::RESULT_LIMIT, 1'b1));
            repeat (cadq_pkg::QUEUE_DEPTH + 1) begin
               send_item(make_message($urandom_range(0, 1) ? cadq_pkg::CLS_AVAIL
                                                            : cadq_pkg::CLS_DISCOVERY));
            end
         end else if (pick <= 3) begin
            send_item(random_bits());
         end else if (pick <= 9) begin
            send_item(make_pop($urandom_range(0, 9) == 0 ? $urandom_range(17, 31)
                                                         : $urandom_range(1, 16),
                               $urandom_range(0, 9) != 0));
         end else begin
            k = $urandom_range(4, 20);
            repeat (k) send_item(make_message(random_class()));
         end
      end
   endtask

   initial begin
      cadq_pkg::req_payload_type it;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_item(make_pop(cadq_pkg::RESULT_LIMIT, 1'b1));
      it = make_message(cadq_pkg::CLS_AVAIL);     it.text_missing = 1'b1; send_item(it);
      it = make_message(cadq_pkg::CLS_UNUSED);                            send_item(it);
      it = make_message(cadq_pkg::CLS_DISCOVERY); it.topic_length = 8'd0; send_item(it);
      it = make_message(cadq_pkg::CLS_TELEMETRY);
      it.topic_length = 8'(cadq_pkg::MAX_TOPIC_BYTES);
      send_item(it);
      it = make_message(cadq_pkg::CLS_AVAIL);
      it.payload_length = 10'(cadq_pkg::MAX_PAYLOAD_BYTES);
      send_item(it);
      it = make_message(cadq_pkg::CLS_AVAIL);
      it.topic_length = 8'hFF; it.payload_length = 10'h3FF;         send_item(it);
      it = make_message(cadq_pkg::CLS_AVAIL);
      it.topic_length = 8'd1; it.payload_length = 10'd0;
      it.message_tag = 16'h0000; it.retain_flag = 1'b0;             send_item(it);
      it = make_message(cadq_pkg::CLS_TELEMETRY);
      it.topic_length   = 8'(cadq_pkg::MAX_TOPIC_BYTES - 1);
      it.payload_length = 10'(cadq_pkg::MAX_PAYLOAD_BYTES - 1);
      it.message_tag = 16'hFFFF; it.retain_flag = 1'b1;             send_item(it);
      send_item(make_message(cadq_pkg::CLS_DISCOVERY));
      send_item(make_pop(4, 1'b0));
      send_item(make_pop(0, 1'b1));
      send_item(make_pop(31, 1'b1));

      write_qos(cadq_pkg::QOS_MAX);
      queue_random_items(110);

      write_qos(cadq_pkg::QOS_RELIABLE);
      holds_requested++;
      repeat (40) send_item(make_message(random_class()));
      send_item(make_pop(cadq_pkg::RESULT_LIMIT, 1'b1));

      write_qos(cadq_pkg::QOS_OVER);
      queue_random_items(110);

      write_qos(2'd0);
      quiet = 1'b1;
      queue_random_items(80);

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (predicted_beats.size() != 0) begin
         mismatches++;
         $display("%0t: %0d beats expected, got none", $time, predicted_beats.size());
      end
      $display("Covered %0d items and %0d result beats, %0d evictions, %0d refusals,",
               items_accepted, beats_seen, shadow_dropped, shadow_rejected);
      $display("across four QoS settings with one long receiver hold-off.");
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
